// File: hw/rtl/lru_cache_replacement_defines.svh
// ----------------------------------------------------------------------------
// LRU cache replacement: assertion macros
// Shared assertion macros for the modules of the replacement block.
// ----------------------------------------------------------------------------
`ifndef LRU_CACHE_REPLACEMENT_DEFINES_SVH
`define LRU_CACHE_REPLACEMENT_DEFINES_SVH

// Plain property, checked at every rising edge outside reset.
`define LCR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define LCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/lcr_pkg.sv
// ----------------------------------------------------------------------------
// LRU cache replacement package
// Types and constants shared by the modules of the replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package lcr_pkg;

   localparam int LCR_ENTRIES   = 64;
   localparam int KEY_W         = 64;
   localparam int CAP_W         = 7;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 3;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // Register index taken from the word address.
   localparam logic CSR_IDX_CAPACITY = 1'b0;

   localparam logic CMD_ACCESS = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   typedef struct packed {
      logic             command;
      logic [KEY_W-1:0] key;
   } lcr_req_type;

   typedef struct packed {
      logic             hit;
      logic             evicted_valid;
      logic [KEY_W-1:0] victim_key;
      logic             remove_error;
   } lcr_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic lookup;
      logic update;
   } lcr_ctrl_type;

endpackage

`default_nettype wire

// File: hw/rtl/lcr_ram.sv
// ----------------------------------------------------------------------------
// LRU cache replacement: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lcr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: hw/rtl/lcr_ctrl.sv
// ----------------------------------------------------------------------------
// LRU cache replacement: controller
// Sequences each request through a lookup and an update cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_cache_replacement_defines.svh"

module lcr_ctrl
   import lcr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   output lcr_ctrl_type      cmd,
   output logic              rsp_valid
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LOOKUP = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign busy   = (state_ff == ST_LOOKUP);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = accept ? ST_LOOKUP : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = (state_ff == ST_UPDATE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign cmd.capture = accept;
   assign cmd.lookup  = (state_ff == ST_LOOKUP);
   assign cmd.update  = (state_ff == ST_UPDATE);
   assign rsp_valid   = rsp_valid_ff;

   `LCR_ASSERT_NEXT(a_lookup_then_update, clock, reset, state_ff == ST_LOOKUP, state_ff == ST_UPDATE, "lookup not followed by update")
   `LCR_ASSERT_NEXT(a_update_gives_word, clock, reset, state_ff == ST_UPDATE, rsp_valid_ff, "update produced no result word")
   `LCR_ASSERT(a_no_accept_in_lookup, clock, reset, !(cmd.capture && cmd.lookup), "request taken during lookup")

endmodule

`default_nettype wire

// File: hw/rtl/lcr_datapath.sv
// ----------------------------------------------------------------------------
// LRU cache replacement: datapath
// Entry cells with keys, valid bits and recency ranks, plus the victim key RAM.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_cache_replacement_defines.svh"

module lcr_datapath
   import lcr_pkg::*;
#(
   parameter int ENTRIES = LCR_ENTRIES
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire lcr_ctrl_type cmd,
   input  wire lcr_req_type  req_data,
   input  wire logic [CAP_W-1:0] capacity,
   output lcr_rsp_type       rsp_data
);

   localparam int IW    = $clog2(ENTRIES);
   localparam int RW    = $clog2(ENTRIES);
   localparam int OW    = $clog2(ENTRIES + 1);
   localparam int CMP_W = ((OW > CAP_W) ? OW : CAP_W) + 1;

   // Entry cells.
   logic [KEY_W-1:0] key_ff   [ENTRIES];
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [RW-1:0]    rank_ff  [ENTRIES];
   logic [RW-1:0]    rank_in  [ENTRIES];
   logic [OW-1:0]    occ_ff, occ_in;

   // Request and lookup results.
   lcr_req_type      req_ff;
   logic [ENTRIES-1:0] match_ff;
   logic             hit_ff, evict_ff;
   logic [RW-1:0]    hit_rank_ff;
   logic [IW-1:0]    slot_ff;
   lcr_rsp_type      rsp_ff, rsp_in;

   // Lookup logic.
   logic [ENTRIES-1:0] match, victim_oh, free_oh;
   logic [IW-1:0]    victim_idx, free_idx;
   logic [RW-1:0]    hit_rank;
   logic [CMP_W-1:0] cap_eff, cap_ext, occ_ext;
   logic             evict;
   logic [KEY_W-1:0] ram_rd_data;

   always_comb begin
      cap_ext = CMP_W'(capacity);
      occ_ext = CMP_W'(occ_ff);
      if (cap_ext == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         cap_eff = CMP_W'(ENTRIES);
      end else begin
         cap_eff = cap_ext;
      end
   end

   always_comb begin
      hit_rank   = '0;
      victim_idx = '0;
      free_idx   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i]     = valid_ff[i] && (key_ff[i] == req_ff.key);
         victim_oh[i] = valid_ff[i] && (OW'(rank_ff[i]) == occ_ff - OW'(1));
      end
      free_oh = ~valid_ff & (valid_ff + ENTRIES'(1));
      for (int i = 0; i < ENTRIES; i++) begin
         if (match[i])     hit_rank   = hit_rank | rank_ff[i];
         if (victim_oh[i]) victim_idx = victim_idx | IW'(i);
         if (free_oh[i])   free_idx   = free_idx | IW'(i);
      end
      evict = (req_ff.command == CMD_ACCESS) && !(|match) && (occ_ext >= cap_eff);
   end

   // The victim key is read while the lookup runs and is ready for the update.
   lcr_ram #(
      .WIDTH(KEY_W),
      .DEPTH(ENTRIES)
   ) u_key_ram (
      .clock      (clock),
      .wr_en      (cmd.update && (req_ff.command == CMD_ACCESS) && !hit_ff),
      .wr_addr    (slot_ff),
      .wr_data    (req_ff.key),
      .rd_addr    (victim_idx),
      .rd_data_ff (ram_rd_data)
   );

   // Cell updates.
   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (req_ff.command == CMD_REMOVE) begin
         if (hit_ff) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (match_ff[i]) begin
                  valid_in[i] = 1'b0;
                  rank_in[i]  = '0;
               end else if (valid_ff[i] && rank_ff[i] > hit_rank_ff) begin
                  rank_in[i] = rank_ff[i] - RW'(1);
               end
            end
            occ_in = occ_ff - OW'(1);
         end
      end else if (hit_ff) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (match_ff[i]) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && rank_ff[i] < hit_rank_ff) begin
               rank_in[i] = rank_ff[i] + RW'(1);
            end
         end
      end else begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (IW'(i) == slot_ff) begin
               valid_in[i] = 1'b1;
               rank_in[i]  = '0;
            end else if (valid_ff[i]) begin
               rank_in[i] = rank_ff[i] + RW'(1);
            end
         end
         if (!evict_ff) occ_in = occ_ff + OW'(1);
      end
   end

   always_comb begin
      rsp_in.hit           = hit_ff;
      rsp_in.evicted_valid = evict_ff;
      rsp_in.victim_key    = evict_ff ? ram_rd_data : '0;
      rsp_in.remove_error  = (req_ff.command == CMD_REMOVE) && !hit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (cmd.update) begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.lookup) begin
         match_ff    <= match;
         hit_ff      <= |match;
         hit_rank_ff <= hit_rank;
         evict_ff    <= evict;
         slot_ff     <= evict ? victim_idx : free_idx;
      end
      if (cmd.update) begin
         rsp_ff <= rsp_in;
         if ((req_ff.command == CMD_ACCESS) && !hit_ff) begin
            key_ff[slot_ff] <= req_ff.key;
         end
      end
   end

   assign rsp_data = rsp_ff;

   `LCR_ASSERT(a_keys_unique, clock, reset, !cmd.lookup || $onehot0(match), "key held by two entries")
   `LCR_ASSERT(a_occ_matches_valid, clock, reset, $countones(valid_ff) == int'(occ_ff), "occupancy differs from valid count")
   `LCR_ASSERT(a_victim_exists, clock, reset, !(cmd.lookup && evict) || $onehot(victim_oh), "eviction without single victim")

endmodule

`default_nettype wire

// File: hw/rtl/lru_cache_replacement.sv
// ----------------------------------------------------------------------------
// LRU cache replacement
// Fully associative LRU replacement engine with a capacity register.
// ----------------------------------------------------------------------------
// A request word (command and 64-bit key) is taken on a rising edge where
// start is high and busy is low. Command access looks the key up: a hit
// makes the entry most recent, a miss inserts the key as most recent and,
// when the occupancy has reached the capacity, evicts the least recent
// entry and returns its key. Command remove deletes the key, or flags
// remove_error when the key is absent.
// Each request passes through a lookup cycle that compares the key
// against every entry in parallel and reads the victim key from the key
// RAM, and an update cycle that rewrites the recency ranks. The result
// word appears on rsp_data with rsp_valid high for exactly one cycle,
// registered at the end of the update cycle. busy is high only in the
// lookup cycle, so a new request can be taken in the update cycle of
// the one before. The receiver cannot stall; the word is shown once.
// Reset empties the cache at once and sets the capacity to 64.
// The capacity register sits at byte address 0 of the APB-style port and
// should be written only while no request is in flight.
`default_nettype none

module lru_cache_replacement
   import lcr_pkg::*;
#(
   parameter int ENTRIES = LCR_ENTRIES
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel.
   input  wire logic                  start,
   output logic                       busy,
   input  wire lcr_req_type           req_data,
   // Result channel.
   output logic                       rsp_valid,
   output lcr_rsp_type                rsp_data,
   // Configuration port.
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   logic [CAP_W-1:0] cap_ff, cap_in;
   lcr_ctrl_type     cmd;
   logic             csr_write;

   // The register index is the word address; only index zero exists.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cap_in = cap_ff;
      if (csr_write && (paddr[2] == CSR_IDX_CAPACITY)) begin
         cap_in = pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   assign prdata = (paddr[2] == CSR_IDX_CAPACITY) ? CSR_DATA_W'(cap_ff) : '0;

   lcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

   lcr_datapath #(
      .ENTRIES(ENTRIES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .capacity (cap_ff),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

// File: dv/tb_lru_cache_replacement.sv
// ----------------------------------------------------------------------------
// LRU cache replacement testbench
// Self-checking bench that runs directed and random request words through
// the replacement block, predicts every result with its own LRU model and
// compares each result word field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lru_cache_replacement
   import lcr_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD  = 12;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_SHOWN   = 10;
   localparam int POOL_MAX    = 96;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   lcr_req_type           req_data;
   logic                  rsp_valid;
   lcr_rsp_type           rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   lru_cache_replacement i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // The bench's own copy of the cache: keys, valid bits, recency ranks
   // (0 is most recent), occupancy and the raw capacity register value.
   logic [KEY_W-1:0] lru_key [LCR_ENTRIES];
   bit               lru_valid [LCR_ENTRIES];
   int               lru_rank [LCR_ENTRIES];
   int               lru_occupancy;
   int               lru_capacity;

   lcr_rsp_type      pending_results[$];
   logic [KEY_W-1:0] key_pool [POOL_MAX];
   int               pool_size;
   int               idle_pct;
   int               mismatches;
   int               words_sent;
   int               words_checked;
   int               hits_seen;
   int               evictions_seen;
   int               remove_errors_seen;
   int               cycle_count;

   // Clock and the cycle counter that guards against a hung run.
   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, pending_results.size());
         $display("FAIL");
         $finish;
      end
   end

   // Slot with the given key among the valid entries, or -1.
   function automatic int lru_find(logic [KEY_W-1:0] k);
      for (int i = 0; i < LCR_ENTRIES; i++)
         if (lru_valid[i] && lru_key[i] == k) return i;
      return -1;
   endfunction

   // Deletes a slot and closes the gap it leaves in the recency ranks.
   function automatic void lru_drop(int s);
      for (int i = 0; i < LCR_ENTRIES; i++)
         if (lru_valid[i] && i != s && lru_rank[i] > lru_rank[s]) lru_rank[i]--;
      lru_valid[s] = 1'b0;
      lru_rank[s]  = 0;
      if (lru_occupancy > 0) lru_occupancy--;
   endfunction

   // Applies one request word to the bench's cache and returns the result
   // word the block must produce for it.
   function automatic lcr_rsp_type lru_predict(lcr_req_type rq);
      lcr_rsp_type r;
      int          cap;
      int          s;
      int          victim;
      r = '0;
      cap = lru_capacity;
      if (cap < 1) cap = 1;
      if (cap > LCR_ENTRIES) cap = LCR_ENTRIES;
      s = lru_find(rq.key);
      if (rq.command == CMD_REMOVE) begin
         if (s >= 0) begin
            r.hit = 1'b1;
            lru_drop(s);
         end else begin
            r.remove_error = 1'b1;
         end
      end else if (s >= 0) begin
         r.hit = 1'b1;
         for (int i = 0; i < LCR_ENTRIES; i++)
            if (lru_valid[i] && lru_rank[i] < lru_rank[s]) lru_rank[i]++;
         lru_rank[s] = 0;
      end else begin
         // The victim leaves before the new key goes in, so a new key can
         // never evict itself.
         if (lru_occupancy + 1 > cap) begin
            victim = -1;
            for (int i = 0; i < LCR_ENTRIES; i++)
               if (lru_valid[i] && (victim < 0 || lru_rank[i] > lru_rank[victim]))
                  victim = i;
            if (victim >= 0) begin
               r.evicted_valid = 1'b1;
               r.victim_key    = lru_key[victim];
               lru_drop(victim);
            end
         end
         s = -1;
         for (int i = LCR_ENTRIES - 1; i >= 0; i--)
            if (!lru_valid[i]) s = i;
         if (s >= 0) begin
            for (int i = 0; i < LCR_ENTRIES; i++)
               if (lru_valid[i]) lru_rank[i]++;
            lru_key[s]   = rq.key;
            lru_valid[s] = 1'b1;
            lru_rank[s]  = 0;
            lru_occupancy++;
         end
      end
      return r;
   endfunction

   // Result checker: every result word is compared with the oldest
   // expectation. The outputs are sampled at the edge that ends their cycle.
   always @(posedge clock) begin
      lcr_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
               $display("Unexpected result word %p at cycle %0d", rsp_data, cycle_count);
         end else begin
            want = pending_results.pop_front();
            words_checked++;
            if (rsp_data.hit !== want.hit || rsp_data.evicted_valid !== want.evicted_valid ||
                rsp_data.victim_key !== want.victim_key ||
                rsp_data.remove_error !== want.remove_error) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("Mismatch at cycle %0d: expected %p, got %p",
                           cycle_count, want, rsp_data);
            end
         end
      end
   end

   // Sends one request word. Start stays high across back-to-back words;
   // it drops when the sender decides to idle after the word, or in a drain.
   task automatic send_word(logic cmd, logic [KEY_W-1:0] k);
      lcr_req_type rq;
      lcr_rsp_type r;
      rq.command = cmd;
      rq.key     = k;
      start    <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy);
      r = lru_predict(rq);
      pending_results.push_back(r);
      words_sent++;
      hits_seen          += r.hit;
      evictions_seen     += r.evicted_valid;
      remove_errors_seen += r.remove_error;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Lowers start and waits until every expected result has come and the datapath is idle.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes the capacity register while the block is idle.
   task automatic write_capacity(int value);
      drain();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= '0;
      pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      lru_capacity = value & 32'h7f;
   endtask

   task automatic fill_pool(int n);
      pool_size = n;
      for (int i = 0; i < n; i++) key_pool[i] = {$urandom(), $urandom()};
      key_pool[0] = '0;
      key_pool[1] = '1;
   endtask

   // Directed words: key extremes, hit, miss, eviction, removes present and
   // absent, a capacity of zero, and a capacity lowered below the occupancy.
   task automatic test_directed();
      idle_pct = 0;
      send_word(CMD_ACCESS, 64'h0);
      send_word(CMD_ACCESS, '1);
      send_word(CMD_ACCESS, 64'h0);
      send_word(CMD_REMOVE, '1);
      send_word(CMD_REMOVE, '1);
      send_word(CMD_REMOVE, 64'h5555_5555_AAAA_AAAA);
      write_capacity(2);
      send_word(CMD_ACCESS, 64'h1111);
      send_word(CMD_ACCESS, 64'h2222);
      send_word(CMD_ACCESS, 64'h1111);
      send_word(CMD_ACCESS, 64'h3333);
      send_word(CMD_ACCESS, 64'h4444);
      write_capacity(127);
      send_word(CMD_ACCESS, 64'hAAAA_AAAA_5555_5555);
      send_word(CMD_ACCESS, 64'h8000_0000_0000_0001);
      send_word(CMD_ACCESS, 64'h7FFF_FFFF_FFFF_FFFE);
      write_capacity(1);
      send_word(CMD_ACCESS, 64'h5555);
      send_word(CMD_ACCESS, 64'h6666);
      send_word(CMD_REMOVE, 64'h6666);
      send_word(CMD_ACCESS, 64'h7777);
      write_capacity(0);
      send_word(CMD_ACCESS, 64'h8888);
      send_word(CMD_ACCESS, 64'h7777);
   endtask

   // Random words drawn mostly from a key pool so that hits, evictions and
   // removes of present keys are common; a few keys are fresh noise.
   task automatic test_random(int cap, int npool, int nwords, int pct);
      int sel;
      logic [KEY_W-1:0] k;
      write_capacity(cap);
      fill_pool(npool);
      idle_pct = pct;
      for (int n = 0; n < nwords; n++) begin
         sel = $urandom_range(99);
         if (sel < 5) k = {$urandom(), $urandom()};
         else k = key_pool[$urandom_range(pool_size - 1)];
         send_word(($urandom_range(99) < 15) ? CMD_REMOVE : CMD_ACCESS, k);
         // At least once the sender holds off until the block is empty.
         if (n == nwords / 2) drain();
      end
   endtask

   initial begin
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      psel     <= 1'b0;
      penable  <= 1'b0;
      pwrite   <= 1'b0;
      paddr    <= '0;
      pwdata   <= '0;
      cycle_count = 0;
      mismatches = 0;
      words_sent = 0;
      words_checked = 0;
      hits_seen = 0;
      evictions_seen = 0;
      remove_errors_seen = 0;
      idle_pct = 0;
      lru_occupancy = 0;
      lru_capacity = CAP_RESET;
      for (int i = 0; i < LCR_ENTRIES; i++) begin
         lru_key[i]   = '0;
         lru_valid[i] = 1'b0;
         lru_rank[i]  = 0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(64, 96, 110, 0);
      test_random(4, 10, 120, 70);
      test_random($urandom_range(2, 20), 24, 120, 18);
      test_random(127, 80, 130, 0);
      test_random(1, 4, 80, 70);
      test_random(0, 5, 60, 18);
      test_random(LCR_ENTRIES, 90, 160, 70);
      test_random($urandom_range(3, 12), 16, 70, 0);

      drain();
      repeat (10) @(posedge clock);
      $display("Sent %0d words, checked %0d results: %0d hits, %0d evictions,",
               words_sent, words_checked, hits_seen, evictions_seen);
      $display("%0d removes of absent keys, capacities 0 to 127, mismatches %0d.",
               remove_errors_seen, mismatches);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+hw/rtl
hw/rtl/lcr_pkg.sv
hw/rtl/lcr_ram.sv
hw/rtl/lcr_ctrl.sv
hw/rtl/lcr_datapath.sv
hw/rtl/lru_cache_replacement.sv
dv/tb_lru_cache_replacement.sv
